### hw/rtl/ffgm_pkg.sv
// ----------------------------------------------------------------------------
// ffgm_pkg: shared types and constants of the flat-field gain map
//
// Word types of both channels, configuration register indexes, fixed field
// widths, the sequencer state type and the divider status group.
// ----------------------------------------------------------------------------
package ffgm_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS   = 24;
    localparam int FACTOR_BITS   = 32;
    localparam int FRAC_BITS     = 16;
    localparam int FRAME_BITS    = 13;
    localparam int MARGIN_BITS   = 12;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 13;

    // Factor constants
    localparam logic [FACTOR_BITS-1:0] FACTOR_ONE  = 32'h0001_0000;
    localparam logic [FACTOR_BITS-1:0] FACTOR_ZERO = 32'h0000_0000;
    localparam logic [FACTOR_BITS-1:0] FACTOR_SAT  = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MARGIN_LEFT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MARGIN_TOP    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MARGIN_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MARGIN_BOTTOM = 3'd5;

    // Input word
    typedef struct packed {
        logic                          mode;
        logic signed [SAMPLE_BITS-1:0] intensity;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [FACTOR_BITS-1:0] gain_factor;
        logic                   pixel_invalid;
        logic                   any_invalid;
        logic                   frame_last;
    } out_word_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_LOAD,
        ST_AVG_RUN,
        ST_FAC_RUN,
        ST_EMIT
    } seq_state_t;

    // Divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### hw/rtl/ffgm_div.sv
// ----------------------------------------------------------------------------
// ffgm_div: shared restoring divider
//
// One quotient bit per cycle. The dividend bits are shifted out of the top of
// a shift register while quotient bits enter at the bottom; after the last
// step the low 'steps' bits hold the quotient. The remainder starts at
// rem_init, which must be below the divisor.
// ----------------------------------------------------------------------------
module ffgm_div import ffgm_pkg::*; #(
    parameter int DVW = 26,
    parameter int QW  = 66,
    localparam int STW = $clog2(QW + 1)
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [STW-1:0] steps,
    input  logic [DVW-1:0] rem_init,
    input  logic [QW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output div_stat_t      stat,
    output logic [QW-1:0]  quotient
);

    logic [STW-1:0] cnt_reg, cnt_next;
    logic           done_reg, done_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [QW-1:0]  q_reg, q_next;
    logic [DVW-1:0] div_reg, div_next;

    logic [DVW:0]   trial;
    logic [DVW:0]   diff;
    logic           fits;

    // One subtract-and-compare step
    assign trial = {rem_reg, q_reg[QW-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        if (start) begin
            cnt_next = steps;
            rem_next = rem_init;
            q_next   = dividend;
            div_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == STW'(1));
            rem_next  = fits ? diff[DVW-1:0] : trial[DVW-1:0];
            q_next    = {q_reg[QW-2:0], fits};
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

### hw/rtl/flat_field_gain_map.sv
// ----------------------------------------------------------------------------
// flat_field_gain_map: flat-field gain map builder
//
// The calibration frame arrives twice in raster order. Summing-pass words
// (mode 0) accumulate the window pixels and give no result; correction-pass
// words (mode 1) each give one unsigned Q16.16 gain factor.
// ----------------------------------------------------------------------------
// Flow: the sequencer stays idle across summing-pass words. The last
// summing-pass word of a frame also starts the average, a division of the
// window sum by the window pixel count on the shared one-bit-a-cycle
// divider, and no word is taken until it is done. A correction-pass
// window pixel that needs a quotient goes through divider launch, the
// divider steps, capture and output load; any other correction-pass word
// goes straight to output load. The result sits in an output register, so
// the next word is taken while a result waits, until a second result is
// ready to go out.
// ----------------------------------------------------------------------------
module flat_field_gain_map import ffgm_pkg::*; #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration write port
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    // input words
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_word_t                 s_data,
    // result words
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_word_t                m_data
);

    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int CMPW = ((SW > FRAME_BITS) ? SW : FRAME_BITS) + 1;
    localparam int CNTW = 2 * SW;
    localparam int SUMW = SAMPLE_BITS + CNTW;
    localparam int AVGW = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int DVW  = (CNTW > SAMPLE_BITS) ? CNTW : SAMPLE_BITS;
    localparam int QW   = ((SUMW + FRAC_BITS) > FACTOR_BITS) ?
                          (SUMW + FRAC_BITS) : FACTOR_BITS;
    localparam int STW  = $clog2(QW + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FRAME_BITS-1:0]  frame_width_reg, frame_height_reg;
    logic [MARGIN_BITS-1:0] margin_left_reg, margin_top_reg;
    logic [MARGIN_BITS-1:0] margin_right_reg, margin_bottom_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= 13'd1024;
            frame_height_reg  <= 13'd1024;
            margin_left_reg   <= '0;
            margin_top_reg    <= '0;
            margin_right_reg  <= '0;
            margin_bottom_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata;
                CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wdata;
                CFG_MARGIN_LEFT:   margin_left_reg   <= cfg_wdata[MARGIN_BITS-1:0];
                CFG_MARGIN_TOP:    margin_top_reg    <= cfg_wdata[MARGIN_BITS-1:0];
                CFG_MARGIN_RIGHT:  margin_right_reg  <= cfg_wdata[MARGIN_BITS-1:0];
                CFG_MARGIN_BOTTOM: margin_bottom_reg <= cfg_wdata[MARGIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame sides: zero reads as one, oversize saturates
    logic [SW-1:0] w_side, h_side;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_side = SW'(1);
        end else if (32'(frame_width_reg) > MAX_SIDE) begin
            w_side = SW'(MAX_SIDE);
        end else begin
            w_side = SW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_side = SW'(1);
        end else if (32'(frame_height_reg) > MAX_SIDE) begin
            h_side = SW'(MAX_SIDE);
        end else begin
            h_side = SW'(frame_height_reg);
        end
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    seq_state_t              state_reg, state_next;
    logic [SW-1:0]           col_reg, col_next;
    logic [SW-1:0]           row_reg, row_next;
    logic signed [SUMW-1:0]  sum_reg, sum_next;
    logic signed [AVGW-1:0]  avg_reg, avg_next;
    logic                    avg_neg_reg, avg_neg_next;
    logic                    seen_reg, seen_next;
    out_word_t               pend_reg, pend_next;
    logic                    m_valid_reg, m_valid_next;
    out_word_t               m_word_reg, m_word_next;

    // Sequencer controls
    logic accept;
    logic div_start;
    logic div_sel_avg;
    logic emit_load;
    logic out_free;

    // Divider connections
    div_stat_t      div_stat;
    logic [QW-1:0]  div_quot;
    logic [STW-1:0] div_steps;
    logic [DVW-1:0] div_rem_init;
    logic [QW-1:0]  div_dividend;
    logic [DVW-1:0] div_divisor;

    // ------------------------------------------------------------------
    // Pixel position and window test
    // ------------------------------------------------------------------
    logic [SW-1:0]   col_eff, row_eff;
    logic            in_win, last_px, row_end;
    logic [CMPW-1:0] cut_w, cut_h;
    logic [SW-1:0]   span_w, span_h;

    // Clamp the counters into the current frame
    assign col_eff = (col_reg >= w_side) ? (w_side - 1'b1) : col_reg;
    assign row_eff = (row_reg >= h_side) ? (h_side - 1'b1) : row_reg;

    assign in_win = (CMPW'(col_eff) >= CMPW'(margin_left_reg)) &&
                    ((CMPW'(col_eff) + CMPW'(margin_right_reg)) < CMPW'(w_side)) &&
                    (CMPW'(row_eff) >= CMPW'(margin_top_reg)) &&
                    ((CMPW'(row_eff) + CMPW'(margin_bottom_reg)) < CMPW'(h_side));

    assign row_end = (col_eff == (w_side - 1'b1));
    assign last_px = row_end && (row_eff == (h_side - 1'b1));

    // Window size for the average
    assign cut_w  = CMPW'(margin_left_reg) + CMPW'(margin_right_reg);
    assign cut_h  = CMPW'(margin_top_reg) + CMPW'(margin_bottom_reg);
    assign span_w = (cut_w >= CMPW'(w_side)) ? '0 : SW'(CMPW'(w_side) - cut_w);
    assign span_h = (cut_h >= CMPW'(h_side)) ? '0 : SW'(CMPW'(h_side) - cut_h);

    logic [CNTW-1:0] win_count;
    assign win_count = CNTW'(span_w) * CNTW'(span_h);

    // ------------------------------------------------------------------
    // Pixel classification for the correction pass
    // ------------------------------------------------------------------
    logic                  px_bad;
    logic                  avg_pos;
    logic                  fac_sat;
    logic                  need_div;
    logic [AVGW-2:0]       inten_shift;
    logic [FACTOR_BITS-1:0] fac_const;

    assign px_bad      = in_win && (s_data.intensity[SAMPLE_BITS-1] ||
                                    (s_data.intensity == '0));
    assign avg_pos     = !avg_reg[AVGW-1] && (avg_reg != '0);
    assign inten_shift = (AVGW-1)'({s_data.intensity[SAMPLE_BITS-2:0],
                                    {FRAC_BITS{1'b0}}});
    // Quotient reaches 2^32 exactly when avg >= intensity * 2^16
    assign fac_sat     = (avg_reg[AVGW-2:0] >= inten_shift);
    assign need_div    = in_win && !px_bad && avg_pos && !fac_sat;

    always_comb begin
        priority if (!in_win) begin
            fac_const = FACTOR_ONE;
        end else if (px_bad || !avg_pos) begin
            fac_const = FACTOR_ZERO;
        end else begin
            fac_const = FACTOR_SAT;
        end
    end

    // ------------------------------------------------------------------
    // Divider operand selection
    // ------------------------------------------------------------------
    logic [SUMW-1:0] sum_mag;
    logic            sum_neg;

    assign sum_neg = sum_reg[SUMW-1];
    assign sum_mag = sum_neg ? SUMW'(-sum_reg) : SUMW'(sum_reg);

    always_comb begin
        if (div_sel_avg) begin
            div_steps    = STW'(SUMW + FRAC_BITS);
            div_rem_init = '0;
            div_dividend = QW'({sum_mag, {FRAC_BITS{1'b0}}});
            div_divisor  = DVW'(win_count);
        end else begin
            div_steps    = STW'(FACTOR_BITS);
            div_rem_init = DVW'(avg_reg[AVGW-2:FRAC_BITS]);
            div_dividend = {avg_reg[FRAC_BITS-1:0], {(QW-FRAC_BITS){1'b0}}};
            div_divisor  = DVW'(s_data.intensity[SAMPLE_BITS-2:0]);
        end
    end

    ffgm_div #(
        .DVW (DVW),
        .QW  (QW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .steps    (div_steps),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority if (!s_data.mode) begin
                        state_next = last_px ? ST_AVG_LOAD : ST_IDLE;
                    end else if (need_div) begin
                        state_next = ST_FAC_RUN;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_AVG_LOAD: begin
                state_next = (win_count == '0) ? ST_IDLE : ST_AVG_RUN;
            end
            ST_AVG_RUN: begin
                if (div_stat.done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FAC_RUN: begin
                if (div_stat.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready     = 1'b0;
        div_start   = 1'b0;
        div_sel_avg = 1'b0;
        emit_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                div_start = s_valid && s_data.mode && need_div;
            end
            ST_AVG_LOAD: begin
                div_sel_avg = 1'b1;
                div_start   = (win_count != '0);
            end
            ST_AVG_RUN: ;
            ST_FAC_RUN: ;
            ST_EMIT: begin
                emit_load = out_free;
            end
            default: ;
        endcase
    end

    assign accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    logic [AVGW-1:0] avg_mag;
    assign avg_mag = AVGW'(div_quot);

    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        sum_next     = sum_reg;
        avg_next     = avg_reg;
        avg_neg_next = avg_neg_reg;
        seen_next    = seen_reg;
        pend_next    = pend_reg;

        // Take one word: advance position, accumulate, flag
        if (accept) begin
            if (last_px) begin
                col_next = '0;
                row_next = '0;
            end else if (row_end) begin
                col_next = '0;
                row_next = row_eff + 1'b1;
            end else begin
                col_next = col_eff + 1'b1;
                row_next = row_eff;
            end

            if (!s_data.mode) begin
                if (in_win) begin
                    sum_next = sum_reg + SUMW'(s_data.intensity);
                end
            end else begin
                if (last_px) begin
                    sum_next = '0;
                end
                seen_next                 = (seen_reg || px_bad) && !last_px;
                pend_next.gain_factor     = fac_const;
                pend_next.pixel_invalid   = px_bad;
                pend_next.any_invalid     = seen_reg || px_bad;
                pend_next.frame_last      = last_px;
            end

            if (last_px && !s_data.mode) begin
                seen_next = 1'b0;
            end
        end

        // Average launch: note the sign, clear the sum
        if (state_reg == ST_AVG_LOAD) begin
            avg_neg_next = sum_neg;
            sum_next     = '0;
            if (win_count == '0) begin
                avg_next = '0;
            end
        end

        // Average finish: put the sign back
        if ((state_reg == ST_AVG_RUN) && div_stat.done) begin
            avg_next = avg_neg_reg ? AVGW'(-avg_mag) : avg_mag;
        end

        // Factor finish
        if ((state_reg == ST_FAC_RUN) && div_stat.done) begin
            pend_next.gain_factor = div_quot[FACTOR_BITS-1:0];
        end
    end

    // Output register: load a word, drop it once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (emit_load) begin
            m_valid_next = 1'b1;
            m_word_next  = pend_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            sum_reg     <= '0;
            avg_reg     <= '0;
            avg_neg_reg <= 1'b0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            sum_reg     <= sum_next;
            avg_reg     <= avg_next;
            avg_neg_reg <= avg_neg_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

endmodule
